>>> rtl/u2u8_pkg.sv
package u2u8_pkg;

    // Upper six bits that tag a surrogate code unit
    localparam logic [5:0] HIGH_TAG = 6'h36;
    localparam logic [5:0] LOW_TAG  = 6'h37;

    // Base of the high surrogate range, used to rebuild a held unit
    localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;

    // Offset of the supplementary planes
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // UTF-8 byte prefixes
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    // Flushed high surrogates always take three bytes
    localparam logic [1:0] FLUSH_LAST_IDX = 2'd2;

    // What the main part of a job emits
    typedef enum logic [1:0] {
        MAIN_NONE = 2'd0,
        MAIN_MARK = 2'd1,
        MAIN_ENC  = 2'd2
    } main_kind_t;

    // One queued job: an optional flush of a held high surrogate, then the main part
    typedef struct packed {
        logic        flush_en;
        logic [9:0]  flush_bits;
        main_kind_t  main_kind;
        logic [20:0] cp;
    } job_t;

    // Index of the last byte of the UTF-8 sequence for a code point
    function automatic logic [1:0] utf8_last_idx(input logic [20:0] cp);
        logic [1:0] r;
        if (cp[20:16] != 5'd0)
            r = 2'd3;
        else if (cp[15:11] != 5'd0)
            r = 2'd2;
        else if (cp[10:7] != 4'd0)
            r = 2'd1;
        else
            r = 2'd0;
        return r;
    endfunction

    // Byte number idx of the UTF-8 sequence for a code point
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
        logic [1:0] last;
        logic [1:0] pos;
        logic [7:0] b;
        last = utf8_last_idx(cp);
        pos  = last - idx;
        if (last == 2'd0)
        begin
            b = {1'b0, cp[6:0]};
        end
        else if (idx == 2'd0)
        begin
            case (last)
                2'd1:    b = {LEAD2_TAG, cp[10:6]};
                2'd2:    b = {LEAD3_TAG, cp[15:12]};
                default: b = {LEAD4_TAG, cp[20:18]};
            endcase
        end
        else
        begin
            case (pos)
                2'd0:    b = {CONT_TAG, cp[5:0]};
                2'd1:    b = {CONT_TAG, cp[11:6]};
                default: b = {CONT_TAG, cp[17:12]};
            endcase
        end
        return b;
    endfunction

endpackage

>>> rtl/u2u8_front.sv
module u2u8_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       code_unit,
    input  logic              buffer_end,
    output logic              job_push,
    output u2u8_pkg::job_t    job,
    input  logic              job_room
);

    logic       high_pending_reg;
    logic       high_pending_next;
    logic [9:0] high_bits_reg;
    logic [9:0] high_bits_next;
    logic       accept;
    logic       is_high;
    logic       is_low;
    logic       is_zero;

    assign in_ready = job_room;
    assign accept   = in_valid && job_room;

    // Classify the incoming unit
    assign is_high = (code_unit[15:10] == u2u8_pkg::HIGH_TAG);
    assign is_low  = (code_unit[15:10] == u2u8_pkg::LOW_TAG);
    assign is_zero = (code_unit == 16'd0);

    // Build the job and the next surrogate state
    always_comb
    begin
        high_pending_next = high_pending_reg;
        high_bits_next    = high_bits_reg;
        job.flush_en      = 1'b0;
        job.flush_bits    = high_bits_reg;
        job.main_kind     = u2u8_pkg::MAIN_NONE;
        job.cp            = {5'd0, code_unit};
        if (accept)
        begin
            if (high_pending_reg && is_low)
            begin
                job.main_kind     = u2u8_pkg::MAIN_ENC;
                job.cp            = u2u8_pkg::SUPP_BASE
                                    + {1'b0, high_bits_reg, code_unit[9:0]};
                high_pending_next = 1'b0;
            end
            else
            begin
                job.flush_en      = high_pending_reg;
                high_pending_next = 1'b0;
                if (is_zero)
                begin
                    job.main_kind = u2u8_pkg::MAIN_MARK;
                end
                else if (is_high && !buffer_end)
                begin
                    high_pending_next = 1'b1;
                    high_bits_next    = code_unit[9:0];
                end
                else
                begin
                    job.main_kind = u2u8_pkg::MAIN_ENC;
                end
            end
        end
    end

    // Queue a job only when the beat yields output beats
    assign job_push = accept && (job.flush_en || (job.main_kind != u2u8_pkg::MAIN_NONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_pending_reg <= 1'b0;
            high_bits_reg    <= 10'd0;
        end
        else
        begin
            high_pending_reg <= high_pending_next;
            high_bits_reg    <= high_bits_next;
        end
    end

endmodule

>>> rtl/u2u8_fifo.sv
module u2u8_fifo #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             room,
    input  logic             pop,
    output logic             avail,
    output logic [WIDTH-1:0] head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign room    = (count_reg != FULL_CNT);
    assign avail   = (count_reg != '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && room;
    assign do_pop  = pop && avail;

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> rtl/u2u8_back.sv
module u2u8_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_avail,
    input  u2u8_pkg::job_t    job,
    output logic              job_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              byte_valid,
    output logic              string_end,
    output logic              last_of_run
);

    logic        in_main_reg;
    logic [1:0]  idx_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        byte_valid_reg;
    logic        string_end_reg;
    logic        last_reg;

    logic        seg_main;
    logic [20:0] seg_cp;
    logic [1:0]  last_idx;
    logic        seg_done;
    logic        job_done;
    logic        load;
    logic [7:0]  byte_now;
    logic        bvalid_now;
    logic        send_now;

    // Pick the segment in progress: flush first, then the main part
    assign seg_main = in_main_reg || !job.flush_en;

    always_comb
    begin
        seg_cp     = u2u8_pkg::SUPP_BASE;
        last_idx   = u2u8_pkg::FLUSH_LAST_IDX;
        byte_now   = 8'd0;
        bvalid_now = 1'b1;
        send_now   = 1'b0;
        if (!seg_main)
        begin
            seg_cp   = {5'd0, u2u8_pkg::SURR_HIGH_BASE | {6'd0, job.flush_bits}};
            byte_now = u2u8_pkg::utf8_byte(seg_cp, idx_reg);
        end
        else
        begin
            seg_cp = job.cp;
            case (job.main_kind)
                u2u8_pkg::MAIN_MARK:
                begin
                    last_idx   = 2'd0;
                    bvalid_now = 1'b0;
                    send_now   = 1'b1;
                end
                u2u8_pkg::MAIN_ENC:
                begin
                    last_idx = u2u8_pkg::utf8_last_idx(seg_cp);
                    byte_now = u2u8_pkg::utf8_byte(seg_cp, idx_reg);
                end
                default:
                begin
                    last_idx = 2'd0;
                end
            endcase
        end
    end

    assign seg_done = (idx_reg == last_idx);
    assign job_done = seg_done && (seg_main || (job.main_kind == u2u8_pkg::MAIN_NONE));
    assign load     = job_avail && (!out_valid_reg || out_ready);
    assign job_pop  = load && job_done;

    // Step through the bytes of the head job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_main_reg   <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (job_done)
                begin
                    in_main_reg <= 1'b0;
                    idx_reg     <= 2'd0;
                end
                else if (seg_done)
                begin
                    in_main_reg <= 1'b1;
                    idx_reg     <= 2'd0;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the output beat until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= byte_now;
            byte_valid_reg <= bvalid_now;
            string_end_reg <= send_now;
            last_reg       <= job_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = byte_valid_reg;
    assign string_end  = string_end_reg;
    assign last_of_run = last_reg;

endmodule

>>> rtl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder. Each input beat carries one code unit (tdata) and a
// buffer-end flag (tlast); each output beat carries one UTF-8 byte, with tuser
// marking a real byte or the end-of-string marker a zero unit produces, and tlast
// flagging the final beat caused by one input beat. The front stage takes one input
// beat per cycle while the job queue (QUEUE_DEPTH entries) has room; the back stage
// emits one output beat per cycle while m_axis_tready is high, and an input beat
// yields 1 to 3 bytes for a BMP unit, 4 for a surrogate pair, up to 6 when a
// held high surrogate is flushed ahead of a new unit, and none for a high surrogate
// that is held.
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  logic        s_axis_tlast,   // buffer_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] string_end
    output logic        m_axis_tlast    // last_of_run
);

    localparam int JOB_W = $bits(u2u8_pkg::job_t);

    u2u8_pkg::job_t job_in;
    u2u8_pkg::job_t job_head;
    logic           job_push;
    logic           job_room;
    logic           job_pop;
    logic           job_avail;

    u2u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .code_unit  (s_axis_tdata),
        .buffer_end (s_axis_tlast),
        .job_push   (job_push),
        .job        (job_in),
        .job_room   (job_room)
    );

    u2u8_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .room      (job_room),
        .pop       (job_pop),
        .avail     (job_avail),
        .head      (job_head)
    );

    u2u8_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_avail   (job_avail),
        .job         (job_head),
        .job_pop     (job_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata),
        .byte_valid  (m_axis_tuser[0]),
        .string_end  (m_axis_tuser[1]),
        .last_of_run (m_axis_tlast)
    );

endmodule

>>> rtl/u2u8_checker.sv
module u2u8_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled output beat holds its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    // Every beat is either a byte or the end marker, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] != m_axis_tuser[1]))
        else $error("beat is neither byte nor marker");

    // The end marker carries a zero byte and closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata == 8'd0) && m_axis_tlast)
        else $error("end marker malformed");

    // An ASCII byte always closes its run: any earlier byte is a lead or continuation byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] && !m_axis_tlast
            |-> (m_axis_tdata[7:6] == 2'b11) || (m_axis_tdata[7:6] == 2'b10))
        else $error("ASCII byte not at the end of its run");

endmodule

bind utf16_to_utf8_transcoder u2u8_checker u_checker (.*);
